### rtl/core/huffman_code_bit_packer_macros.svh
// assertion macros used by the bit packer checker
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define HCBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is high
`define HCBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define HCBP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hcbp_pkg.sv
// shared types and constants of the huffman code bit packer
package hcbp_pkg;

  localparam int BYTE_W = 8;
  localparam int ACC_W  = 7;
  localparam int PEND_W = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

endpackage

### rtl/core/hcbp_ram.sv
// generic single write port ram with registered read
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/huffman_code_bit_packer.sv
// static huffman encoder back end: code table and msb-first bit packer
//
// input channel (in_valid/in_ready) takes one item per cycle while in_ready
// is high: opcode load writes code_word/code_length into the code table
// entry of symbol, encode appends the code of symbol to the bit accumulator,
// flush pads a partial byte with zeros. loads longer than the code limit and
// loads or encodes of symbols beyond the table are dropped without effect.
// output channel (out_valid/out_ready) gives the packed bytes of each item
// in order, first code bit in bit 7, last set on the final byte of an item.
// an encode or flush passes the accumulator stage (with the table read
// register for an encode), then the output buffer, before its first byte shows.
// throughput: one item per cycle while each item gives at most one byte and
// the receiver takes every byte; an item giving more bytes holds the output
// buffer, and the accumulator stage and input wait, until its last byte goes.
// the accumulator update (shift, merge, byte split) is combinational.
// a stalled receiver freezes the output buffer; in_ready drops as soon as
// the accumulator stage holds an item that cannot move on.
// reset (rst, synchronous) empties the accumulator and both stages and holds
// in_ready low; the code table is not cleared and must be loaded first
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_BITS = 32,
  parameter int SYMBOLS       = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [7:0]        symbol,
  input  logic [31:0]       code_word,
  input  logic [5:0]        code_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last
);

  // stored code width: the input word carries at most 32 bits
  localparam int CODE_W  = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
  localparam int LEN_W   = $clog2(CODE_W + 1);
  localparam int ENTRY_W = LEN_W + CODE_W;
  localparam int ADDR_W  = $clog2(SYMBOLS);
  // pending bits plus one code
  localparam int TOT_W   = CODE_W + ACC_W;
  localparam int NB      = TOT_W / BYTE_W;
  localparam int AW      = BYTE_W * ((TOT_W + BYTE_W - 1) / BYTE_W);
  localparam int NW      = $clog2(TOT_W + 1);
  localparam int SW      = $clog2(AW + 1);
  localparam int CW      = $clog2(NB + 1);

  // input decode
  op_t                op_in;
  logic               in_accept;
  logic               sym_ok;
  logic               len_ok;
  logic [31:0]        code_mask;
  logic               tbl_we;
  logic               tbl_re;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic               s1_enter;

  // accumulator stage
  logic               s1_valid;
  op_t                s1_op;
  logic               s1_adv;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [PEND_W-1:0]  pending;
  logic [PEND_W-1:0]  pending_next;
  logic [LEN_W-1:0]   clen;
  logic [CODE_W-1:0]  ccode;
  logic [TOT_W-1:0]   total;
  logic [NW-1:0]      n_bits;
  logic [SW-1:0]      shamt;
  logic [AW-1:0]      aligned;
  logic [CW-1:0]      res_count;
  logic [BYTE_W-1:0]  res_bytes [NB];

  // output buffer
  logic [BYTE_W-1:0]  ob_bytes [NB];
  logic [CW-1:0]      ob_count;
  logic               out_accept;

  assign op_in     = op_t'(opcode);
  assign in_accept = in_valid && in_ready;
  assign sym_ok    = ({1'b0, symbol} < 9'(SYMBOLS));
  // longer codes than the table holds are ignored
  assign len_ok    = (code_length <= 6'(CODE_W));
  // bits above the code length are dropped; length 32 keeps the whole word
  assign code_mask = ~({32{1'b1}} << code_length);
  assign tbl_wdata = {code_length[LEN_W-1:0], CODE_W'(code_word & code_mask)};

  always_comb begin
    tbl_we   = 1'b0;
    tbl_re   = 1'b0;
    s1_enter = 1'b0;
    unique case (op_in)
      OP_LOAD: begin
        tbl_we = in_accept && sym_ok && len_ok;
      end
      OP_ENCODE: begin
        tbl_re   = in_accept && sym_ok;
        s1_enter = in_accept && sym_ok;
      end
      OP_FLUSH: begin
        s1_enter = in_accept;
      end
      default: begin
        // unused opcode: accepted and dropped
      end
    endcase
  end

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOLS)
  ) u_code_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (symbol[ADDR_W-1:0]),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (symbol[ADDR_W-1:0]),
    .rdata (tbl_rdata)
  );

  // the accumulator stage moves on once the buffer is empty or frees now
  assign out_accept = out_valid && out_ready;
  assign s1_adv     = s1_valid && ((ob_count == '0) ||
                                   ((ob_count == CW'(1)) && out_ready));
  // no item is taken while reset is high
  assign in_ready   = !rst && (!s1_valid || s1_adv);

  // merge the pending bits with the code and split off whole bytes
  assign clen    = tbl_rdata[ENTRY_W-1 -: LEN_W];
  assign ccode   = tbl_rdata[CODE_W-1:0];
  assign total   = (TOT_W'(acc) << clen) | TOT_W'(ccode);
  assign n_bits  = NW'(pending) + NW'(clen);
  // left align so the oldest pending bit lands in the top bit
  assign shamt   = SW'(AW) - SW'(n_bits);
  assign aligned = AW'(total) << shamt;

  always_comb begin
    res_count    = '0;
    acc_next     = acc;
    pending_next = pending;
    for (int k = 0; k < NB; k++) begin
      res_bytes[k] = aligned[AW-1-BYTE_W*k -: BYTE_W];
    end
    unique case (s1_op)
      OP_ENCODE: begin
        res_count    = CW'(n_bits >> PEND_W);
        acc_next     = ACC_W'(total) & ~({ACC_W{1'b1}} << n_bits[PEND_W-1:0]);
        pending_next = n_bits[PEND_W-1:0];
      end
      OP_FLUSH: begin
        // empty flush gives nothing
        res_count    = (pending != '0) ? CW'(1) : '0;
        res_bytes[0] = BYTE_W'(acc) << (4'(BYTE_W) - 4'(pending));
        acc_next     = '0;
        pending_next = '0;
      end
      default: begin
        res_count = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
      pending  <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid <= 1'b0;
        acc      <= acc_next;
        pending  <= pending_next;
      end
      if (s1_enter) begin
        s1_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_enter) begin
      s1_op <= op_in;
    end
  end

  // output buffer: bytes leave from slot 0, the rest shift down
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_count <= '0;
    end else if (s1_adv) begin
      ob_count <= res_count;
    end else if (out_accept) begin
      ob_count <= ob_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < NB; k++) begin
        ob_bytes[k] <= res_bytes[k];
      end
    end else if (out_accept) begin
      for (int k = 0; k < NB - 1; k++) begin
        ob_bytes[k] <= ob_bytes[k+1];
      end
    end
  end

  assign out_valid = (ob_count != '0);
  assign out_byte  = ob_bytes[0];
  assign last      = (ob_count == CW'(1));

endmodule

### rtl/core/hcbp_checker.sv
// port level checks of the huffman code bit packer, bound to the top level
`include "huffman_code_bit_packer_macros.svh"

module hcbp_checker import hcbp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              last
);

  // the input only stalls behind a waiting output byte
  `HCBP_ASSERT_IMP(a_stall_needs_output, !in_ready, out_valid, "input stalled with no output")

  // a byte that is not last is always followed by another of the same item
  `HCBP_ASSERT_NXT(a_item_continues, out_valid && !last, out_valid, "item ended without last")

  // a stalled output byte holds
  `HCBP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte) && $stable(last), "output changed under stall")

  // reset empties the output
  `HCBP_ASSERT_RST(a_reset_empty, rst, !out_valid, "output valid after reset")

endmodule

bind huffman_code_bit_packer hcbp_checker u_checker (.*);

### sim/huffman_code_bit_packer_tb.sv
// self-checking huffman code bit packer testbench: directed and random items of each opcode
`timescale 1ns / 100ps

module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  localparam int MAX_CODE_BITS = 32;
  localparam int SYMBOLS       = 256;
  localparam int RANDOM_ITEMS  = 146;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 200000;

  // opcode value that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] word;
    logic [5:0]  len;
  } huff_item_t;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } packed_byte_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode      = '0;
  logic [7:0]  symbol      = '0;
  logic [31:0] code_word   = '0;
  logic [5:0]  code_length = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  huffman_code_bit_packer #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .SYMBOLS      (SYMBOLS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .symbol     (symbol),
    .code_word  (code_word),
    .code_length(code_length),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last       (last)
  );

  always #1 clk = ~clk;

  // items waiting to be driven, filled up front
  huff_item_t   items_to_send[$];
  // bytes the packer still owes, oldest first
  packed_byte_t packed_bytes_due[$];

  // mirror of the block state, updated on every accepted item
  logic [31:0] code_mirror[SYMBOLS];
  logic [5:0]  length_mirror[SYMBOLS];
  logic [6:0]  acc_mirror = '0;
  int          pending_bits = 0;

  // which entries the stimulus has loaded so far (encode only those)
  bit          entry_loaded[SYMBOLS];

  int errors      = 0;
  int n_items     = 0;
  int n_accepted  = 0;
  int cycles      = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // idle length: mostly none, often short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // expected bytes of one accepted item
  function automatic void pack_item(input logic [1:0] op, input logic [7:0] sym,
                                    input logic [31:0] word, input logic [5:0] len);
    logic [63:0]  total;
    logic [7:0]   pad;
    int           n;
    int           clen;
    packed_byte_t pb;
    case (op)
      OP_LOAD: begin
        // overlong codes leave the entry untouched, bits above the length drop
        if (sym < SYMBOLS && len <= MAX_CODE_BITS && len <= 32) begin
          code_mirror[sym]   = 32'(word & ((64'd1 << len) - 64'd1));
          length_mirror[sym] = len;
        end
      end
      OP_ENCODE: begin
        if (sym < SYMBOLS) begin
          clen  = length_mirror[sym];
          total = ({57'd0, acc_mirror} << clen) | {32'd0, code_mirror[sym]};
          n     = pending_bits + clen;
          while (n >= 8) begin
            n       -= 8;
            pb.data  = 8'(total >> n);
            pb.fin   = (n < 8);
            packed_bytes_due.insert(packed_bytes_due.size(), pb);
          end
          acc_mirror   = 7'(total & ((64'd1 << n) - 64'd1));
          pending_bits = n;
        end
      end
      OP_FLUSH: begin
        // zero padding below the pending bits, nothing when empty
        if (pending_bits != 0) begin
          pad     = {1'b0, acc_mirror};
          pb.data = pad << (8 - pending_bits);
          pb.fin  = 1'b1;
          packed_bytes_due.insert(packed_bytes_due.size(), pb);
          acc_mirror   = '0;
          pending_bits = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(input logic [1:0] op, input logic [7:0] sym,
                                   input logic [31:0] word, input logic [5:0] len);
    huff_item_t it;
    it.op   = op;
    it.sym  = sym;
    it.word = word;
    it.len  = len;
    items_to_send.insert(items_to_send.size(), it);
    if (op == OP_LOAD && len <= MAX_CODE_BITS) entry_loaded[sym] = 1'b1;
  endfunction

  function automatic logic [7:0] any_loaded_symbol();
    logic [7:0] s;
    do s = 8'($urandom_range(0, SYMBOLS - 1)); while (!entry_loaded[s]);
    return s;
  endfunction

  // input side: present the next item once the previous one is taken
  int gap_left = 0;
  int calm_in  = 0;

  always @(posedge clk) begin : drive
    huff_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        pack_item(opcode, symbol, code_word, code_length);
        n_accepted++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        it          = items_to_send.pop_front();
        opcode      <= it.op;
        symbol      <= it.sym;
        code_word   <= it.word;
        code_length <= it.len;
        in_valid    <= 1'b1;
        if (calm_in > 0) begin
          calm_in--;
        end else begin
          gap_left = idle_len();
          if ($urandom_range(0, 24) == 0) calm_in = $urandom_range(15, 50);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random back-pressure with calm stretches
  int stall_left = 0;
  int calm_out   = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (calm_out > 0) begin
        calm_out--;
      end else begin
        if ($urandom_range(0, 2) == 0) stall_left = idle_len();
        if ($urandom_range(0, 29) == 0) calm_out = $urandom_range(20, 60);
      end
    end
  end

  // compare every taken byte with the oldest one owed
  always @(posedge clk) begin : watch
    packed_byte_t pb;
    if (!rst && out_valid && out_ready) begin
      if (packed_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last));
      end else begin
        pb = packed_bytes_due.pop_front();
        if (out_byte !== pb.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, pb.data));
        if (last !== pb.fin)
          report_mismatch($sformatf("last %0b, want %0b (byte %02h)", last, pb.fin, pb.data));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    int k;
    logic [5:0] len;

    for (k = 0; k < SYMBOLS; k++) begin
      code_mirror[k]   = '0;
      length_mirror[k] = '0;
      entry_loaded[k]  = 1'b0;
    end

    // directed: zero-length code with excess word bits, empty flush
    add_item(OP_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
    add_item(OP_ENCODE, 8'd0, $urandom, 6'($urandom));
    add_item(OP_FLUSH, 8'hFF, $urandom, 6'($urandom));
    // longest code, all ones, four bytes from one item
    add_item(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    add_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    // short code with dropped upper bits
    add_item(OP_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd3);
    add_item(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    // overlong loads must not disturb entry 1
    add_item(OP_LOAD, 8'd1, 32'h0, 6'd33);
    add_item(OP_LOAD, 8'd1, 32'h1234_5678, 6'd63);
    add_item(OP_ENCODE, 8'd1, 32'hFFFF_FFFF, 6'h3F);
    // unused opcode with every field at its top value
    add_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // 32-bit code on top of six pending bits
    add_item(OP_LOAD, 8'hAA, 32'hAAAA_5555, 6'd32);
    add_item(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
    add_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    add_item(OP_LOAD, 8'h55, 32'h0, 6'd8);
    add_item(OP_ENCODE, 8'h55, 32'h0, 6'd0);
    add_item(OP_ENCODE, 8'd1, 32'h0, 6'd0);
    add_item(OP_LOAD, 8'd2, 32'h1, 6'd1);
    add_item(OP_ENCODE, 8'd2, 32'h0, 6'd0);
    add_item(OP_LOAD, 8'h80, 32'h7F, 6'd7);
    add_item(OP_ENCODE, 8'h80, 32'h0, 6'd0);
    add_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    add_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);

    // random: loads of mostly short codes, encodes of loaded entries, flushes, unused opcodes
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        r = $urandom_range(0, 99);
        if (r < 10)      len = 6'd0;
        else if (r < 70) len = 6'($urandom_range(1, 12));
        else if (r < 92) len = 6'($urandom_range(13, 32));
        else             len = 6'($urandom_range(33, 63));
        add_item(OP_LOAD, 8'($urandom), $urandom, len);
      end else if (r < 80) begin
        add_item(OP_ENCODE, any_loaded_symbol(), $urandom, 6'($urandom));
      end else if (r < 93) begin
        add_item(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
      end else begin
        add_item(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom));
      end
    end
    // push out whatever is still pending
    add_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    n_items = items_to_send.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_items) @(posedge clk);
    while (packed_bytes_due.size() != 0) @(posedge clk);
    // catch any stray byte after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (packed_bytes_due.size() != 0)
      report_mismatch($sformatf("%0d bytes never came", packed_bytes_due.size()));
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
